[src/lsf_pkg.sv]
// Shared types and constants for the line substring filter.
// Holds the request, result and configuration write structs, the store write
// struct and the front-to-back line descriptor. No dependencies.
package lsf_pkg;

  // Configuration port geometry and register indexes.
  localparam int DATA_W    = 64;
  localparam int REG_IDX_W = 2;
  localparam int LEN_W     = 5;

  localparam logic [REG_IDX_W-1:0] REG_NEEDLE_LOW    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_NEEDLE_HIGH   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_NEEDLE_LENGTH = 2'd2;

  // Needle bytes held by the two needle registers.
  localparam int NEEDLE_BYTES = 16;

  // Field widths that cover the whole supported range of line lengths.
  localparam int LINE_LEN_W  = 7;
  localparam int STORE_IDX_W = 6;

  // Byte codes with special meaning.
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] ZERO_BYTE    = 8'h00;

  // One input request.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_stream;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_line;
  } out_item_t;

  // One configuration write.
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
  } cfg_wr_t;

  // A closed line that must be emitted: which store bank and how many bytes.
  typedef struct packed {
    logic                  bank;
    logic [LINE_LEN_W-1:0] length;
  } line_desc_t;

  // One write into the line store.
  typedef struct packed {
    logic                   en;
    logic                   bank;
    logic [STORE_IDX_W-1:0] index;
    logic [7:0]             data;
  } store_wr_t;

endpackage

[src/lsf_front.sv]
// Front part of the line substring filter: configuration registers, line
// gathering, sliding window match and line close detection.
// Depends on lsf_pkg.
module lsf_front
  import lsf_pkg::*;
#(
  parameter int LINE_MAX   = 64,
  parameter int NEEDLE_MAX = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_wr_t    cfg,
  input  logic       accept,
  input  in_item_t   item,
  output store_wr_t  store_wr,
  output logic       desc_push,
  output line_desc_t desc
);

  localparam int CNT_W = $clog2(LINE_MAX);

  logic [DATA_W-1:0] needle_low;
  logic [DATA_W-1:0] needle_high;
  logic [LEN_W-1:0]  needle_length;

  logic [CNT_W-1:0]  count;
  logic [7:0]        window [NEEDLE_MAX];
  logic              match;
  logic              zero_seen;
  logic              bank;

  logic [CNT_W-1:0]  count_next;
  logic [7:0]        window_next [NEEDLE_MAX];
  logic              zero_seen_next;
  logic              match_next;
  logic [LEN_W-1:0]  len_used;
  logic [7:0]        needle_byte [NEEDLE_BYTES];
  logic              hit;
  logic              is_byte;
  logic              byte_close;
  logic              eos_close;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      needle_low    <= '0;
      needle_high   <= '0;
      needle_length <= '0;
    end else if (cfg.en) begin
      unique case (cfg.index)
        REG_NEEDLE_LOW:    needle_low    <= cfg.data;
        REG_NEEDLE_HIGH:   needle_high   <= cfg.data;
        REG_NEEDLE_LENGTH: needle_length <= cfg.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Needle length in use, clamped to the window size.
  assign len_used = (needle_length > LEN_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX)
                                                         : needle_length;

  // Needle bytes in order, byte zero first.
  always_comb begin
    for (int k = 0; k < NEEDLE_BYTES; k++) begin
      needle_byte[k] = (k < 8) ? needle_low[8*(k%8) +: 8] : needle_high[8*(k%8) +: 8];
    end
  end

  // Window after taking the incoming byte; entry zero is the newest byte.
  always_comb begin
    window_next[0] = item.in_byte;
    for (int k = 1; k < NEEDLE_MAX; k++) begin
      window_next[k] = window[k-1];
    end
  end

  // Compare the newest bytes against the needle, newest against its last byte.
  always_comb begin
    logic [LEN_W-1:0] pos;
    hit = 1'b1;
    for (int j = 0; j < NEEDLE_MAX; j++) begin
      pos = len_used - LEN_W'(j) - LEN_W'(1);
      if (LEN_W'(j) < len_used) begin
        if (window_next[j] != needle_byte[pos[3:0]]) begin
          hit = 1'b0;
        end
      end
    end
  end

  // Line state after a data byte.
  assign is_byte        = accept && !item.end_of_stream;
  assign count_next     = count + CNT_W'(1);
  assign zero_seen_next = zero_seen || (item.in_byte == ZERO_BYTE);
  assign match_next     = match || (!zero_seen_next && (len_used != '0) &&
                                    (32'(count_next) >= 32'(len_used)) && hit);

  // Line close on a newline, on a full store, or on end of stream.
  assign byte_close = is_byte && ((item.in_byte == NEWLINE_BYTE) ||
                                  (count_next >= CNT_W'(LINE_MAX - 1)));
  assign eos_close  = accept && item.end_of_stream && (count != '0);

  // Store write for every data byte and descriptor for a matching line.
  always_comb begin
    store_wr.en    = is_byte;
    store_wr.bank  = bank;
    store_wr.index = STORE_IDX_W'(count);
    store_wr.data  = item.in_byte;

    desc.bank = bank;
    if (byte_close) begin
      desc.length = LINE_LEN_W'(count_next);
      desc_push   = match_next && (len_used != '0);
    end else begin
      desc.length = LINE_LEN_W'(count);
      desc_push   = eos_close && match && (len_used != '0);
    end
  end

  // Line state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      match     <= 1'b0;
      zero_seen <= 1'b0;
      bank      <= 1'b0;
      for (int k = 0; k < NEEDLE_MAX; k++) begin
        window[k] <= '0;
      end
    end else begin
      if (desc_push) begin
        bank <= !bank;
      end
      if (byte_close || (accept && item.end_of_stream)) begin
        count     <= '0;
        match     <= 1'b0;
        zero_seen <= 1'b0;
        for (int k = 0; k < NEEDLE_MAX; k++) begin
          window[k] <= '0;
        end
      end else if (is_byte) begin
        count     <= count_next;
        match     <= match_next;
        zero_seen <= zero_seen_next;
        for (int k = 0; k < NEEDLE_MAX; k++) begin
          window[k] <= window_next[k];
        end
      end
    end
  end

endmodule

[src/lsf_line_queue.sv]
// Two-entry queue of matching-line descriptors between front and back.
// One entry per store bank. Depends on lsf_pkg.
module lsf_line_queue
  import lsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  line_desc_t desc_in,
  input  logic       pop,
  output line_desc_t head,
  output logic       head_valid,
  output logic       full
);

  line_desc_t  entries [2];
  logic        wptr;
  logic        rptr;
  logic [1:0]  fill;

  assign head       = entries[rptr];
  assign head_valid = (fill != 2'd0);
  assign full       = (fill == 2'd2);

  // Payload storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= desc_in;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

[src/lsf_back.sv]
// Back part of the line substring filter: the two-bank line store and the
// readout that replays a matching line into a two-entry result buffer.
// Depends on lsf_pkg.
module lsf_back
  import lsf_pkg::*;
#(
  parameter int LINE_MAX = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  store_wr_t  store_wr,
  input  line_desc_t head,
  input  logic       head_valid,
  output logic       line_done,
  input  logic       pop,
  output logic       empty,
  output out_item_t  result
);

  localparam int DEPTH  = LINE_MAX - 1;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [7:0]      mem [2][DEPTH];
  logic [ADDR_W-1:0] rd_idx;
  logic [7:0]      rd_data;
  logic            rd_last;
  logic            inflight;
  logic            issue;
  logic            last;

  out_item_t       obuf [2];
  logic            owptr;
  logic            orptr;
  logic [1:0]      ocount;
  logic            pop_fire;
  logic [2:0]      credit_use;

  // Line store write port.
  always_ff @(posedge clk) begin
    if (store_wr.en) begin
      mem[store_wr.bank][store_wr.index[ADDR_W-1:0]] <= store_wr.data;
    end
  end

  // Issue a read when the result buffer has room for it after this cycle.
  assign pop_fire   = pop && (ocount != 2'd0);
  assign credit_use = 3'(ocount) + 3'(inflight) - 3'(pop_fire);
  assign issue      = head_valid && (credit_use < 3'd2);
  assign last       = ((LINE_LEN_W'(rd_idx) + LINE_LEN_W'(1)) == head.length);
  assign line_done  = issue && last;

  // Line store read port, registered.
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= mem[head.bank][rd_idx];
      rd_last <= last;
    end
  end

  // Read index and read-in-flight flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx   <= '0;
      inflight <= 1'b0;
    end else begin
      inflight <= issue;
      if (issue) begin
        rd_idx <= last ? '0 : rd_idx + ADDR_W'(1);
      end
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk) begin
    if (inflight) begin
      obuf[owptr] <= '{out_byte: rd_data, last_of_line: rd_last};
    end
  end

  // Result buffer pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      owptr  <= 1'b0;
      orptr  <= 1'b0;
      ocount <= 2'd0;
    end else begin
      if (inflight) begin
        owptr <= !owptr;
      end
      if (pop_fire) begin
        orptr <= !orptr;
      end
      ocount <= ocount + 2'(inflight) - 2'(pop_fire);
    end
  end

  assign empty  = (ocount == 2'd0);
  assign result = obuf[orptr];

endmodule

[src/line_substring_filter_core.sv]
// Line substring filter: one byte request accepted per cycle while full is low.
// With no older line pending, the first byte of a matching line passes the line
// queue, the store read register and the result buffer to the result ports; the
// line then streams one byte per cycle while pop is held. full is high while two
// matching lines hold both store banks, until the older one has been read out.
// Synchronous reset clears line state, needle registers and queues, not the store.
module line_substring_filter_core
  import lsf_pkg::*;
#(
  parameter int LINE_MAX   = 64,
  parameter int NEEDLE_MAX = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  in_item_t             item,
  output logic                 empty,
  input  logic                 pop,
  output out_item_t            result,
  input  logic                 write_enable,
  input  logic [REG_IDX_W-1:0] reg_index,
  input  logic [DATA_W-1:0]    write_data
);

  cfg_wr_t    cfg;
  store_wr_t  store_wr;
  line_desc_t desc;
  line_desc_t head;
  logic       desc_push;
  logic       head_valid;
  logic       line_done;
  logic       accept;

  // Configuration write and request acceptance.
  assign cfg    = '{en: write_enable, index: reg_index, data: write_data};
  assign accept = push && !full;

  lsf_front #(
    .LINE_MAX   (LINE_MAX),
    .NEEDLE_MAX (NEEDLE_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .item      (item),
    .store_wr  (store_wr),
    .desc_push (desc_push),
    .desc      (desc)
  );

  lsf_line_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (desc_push),
    .desc_in    (desc),
    .pop        (line_done),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  lsf_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .store_wr   (store_wr),
    .head       (head),
    .head_valid (head_valid),
    .line_done  (line_done),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule

[verif/line_filter_checker.sv]
// Checker for the line substring filter: watches the request, result and
// register channels, predicts the emitted line bytes and compares them in order.
// Depends on lsf_pkg for the payload structs, register indexes and byte codes.
module line_filter_checker
  import lsf_pkg::*;
#(
  parameter int LINE_MAX   = 64,
  parameter int NEEDLE_MAX = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  in_item_t             item,
  input  logic                 empty,
  input  logic                 pop,
  input  out_item_t            result,
  input  logic                 write_enable,
  input  logic [REG_IDX_W-1:0] reg_index,
  input  logic [DATA_W-1:0]    write_data,
  output int                   failures,
  output int                   bytes_due
);

  // Shadow copy of the needle registers.
  logic [DATA_W-1:0] needle_lo;
  logic [DATA_W-1:0] needle_hi;
  logic [LEN_W-1:0]  needle_size;

  // Shadow copy of the line being gathered.
  logic [7:0] line_buf [LINE_MAX];
  int         line_fill;
  logic [7:0] recent [NEEDLE_BYTES];
  bit         found;
  bit         zero_in_line;

  // Line bytes that the block still owes, oldest first.
  out_item_t line_bytes_due [$];
  out_item_t oldest;

  // Lengths above the needle capacity behave as the full capacity.
  function automatic int active_len();
    return (needle_size > NEEDLE_MAX) ? NEEDLE_MAX : int'(needle_size);
  endfunction

  function automatic logic [7:0] needle_byte(int k);
    if (k < 8) return needle_lo[8*k +: 8];
    return needle_hi[8*(k-8) +: 8];
  endfunction

  task automatic clear_line();
    line_fill = 0;
    foreach (recent[k]) recent[k] = 8'h00;
    found = 1'b0;
    zero_in_line = 1'b0;
  endtask

  // A closed line is owed in full only if the needle was seen in it.
  task automatic close_line();
    out_item_t b;
    if (found && active_len() != 0) begin
      for (int i = 0; i < line_fill; i++) begin
        b.out_byte = line_buf[i];
        b.last_of_line = (i == line_fill - 1);
        line_bytes_due.push_back(b);
      end
    end
    clear_line();
  endtask

  // Advance the line state by one accepted request.
  task automatic filter_request(in_item_t req);
    int n;
    bit hit;
    if (req.end_of_stream) begin
      if (line_fill != 0) close_line();
      else clear_line();
      return;
    end
    if (line_fill + 1 < LINE_MAX) begin
      line_buf[line_fill] = req.in_byte;
      line_fill++;
    end
    for (int k = NEEDLE_BYTES - 1; k > 0; k--) recent[k] = recent[k-1];
    recent[0] = req.in_byte;
    if (req.in_byte == ZERO_BYTE) zero_in_line = 1'b1;
    // Match check on the newest bytes; a zero byte in the line blocks it.
    n = active_len();
    if (!zero_in_line && !found && n != 0 && line_fill >= n) begin
      hit = 1'b1;
      for (int j = 0; j < n; j++) begin
        if (recent[j] != needle_byte(n - 1 - j)) hit = 1'b0;
      end
      found = hit;
    end
    if (req.in_byte == NEWLINE_BYTE || line_fill + 1 >= LINE_MAX) close_line();
  endtask

  task automatic note_failure(string text);
    failures++;
    if (failures <= 10) $display("[%0t] %s", $realtime, text);
  endtask

  // Results are checked before new requests are absorbed in the same cycle.
  always @(posedge clk) begin
    if (rst) begin
      needle_lo = '0;
      needle_hi = '0;
      needle_size = '0;
      clear_line();
      line_bytes_due.delete();
    end else begin
      if (pop && !empty) begin
        if (line_bytes_due.size() == 0) begin
          note_failure($sformatf("result with nothing owed: byte %02h last %0b",
                                 result.out_byte, result.last_of_line));
        end else begin
          oldest = line_bytes_due.pop_front();
          if (result.out_byte !== oldest.out_byte ||
              result.last_of_line !== oldest.last_of_line) begin
            note_failure($sformatf("expected byte %02h last %0b, got byte %02h last %0b",
                                   oldest.out_byte, oldest.last_of_line,
                                   result.out_byte, result.last_of_line));
          end
        end
      end
      if (write_enable) begin
        case (reg_index)
          REG_NEEDLE_LOW:    needle_lo = write_data;
          REG_NEEDLE_HIGH:   needle_hi = write_data;
          REG_NEEDLE_LENGTH: needle_size = write_data[LEN_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) filter_request(item);
    end
    bytes_due <= line_bytes_due.size();
  end

endmodule

[verif/line_substring_filter_core_test.sv]
// Top of the line substring filter testbench: clock, reset, request and
// register stimulus, result draining and the final verdict.
// Depends on lsf_pkg, line_substring_filter_core and line_filter_checker.
module line_substring_filter_core_test;
  import lsf_pkg::*;

  localparam int LINE_MAX     = 64;
  localparam int NEEDLE_MAX   = 16;
  localparam int HALF_PERIOD  = 10;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 2000000;
  localparam int PHASE_ITEMS  = 8;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 push;
  logic                 full;
  in_item_t             item;
  logic                 empty;
  logic                 pop;
  out_item_t            result;
  logic                 write_enable;
  logic [REG_IDX_W-1:0] reg_index;
  logic [DATA_W-1:0]    write_data;
  int                   failures;
  int                   bytes_due;

  // Stimulus control shared between the request side and the result side.
  bit         calm;
  bit         long_hold;
  bit         gappy;
  int         sent_items;
  logic [7:0] needle_text [NEEDLE_BYTES];
  int         needle_used;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  line_substring_filter_core #(
    .LINE_MAX(LINE_MAX),
    .NEEDLE_MAX(NEEDLE_MAX)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .write_enable(write_enable),
    .reg_index(reg_index),
    .write_data(write_data)
  );

  line_filter_checker #(
    .LINE_MAX(LINE_MAX),
    .NEEDLE_MAX(NEEDLE_MAX)
  ) line_check (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .item(item),
    .empty(empty),
    .pop(pop),
    .result(result),
    .write_enable(write_enable),
    .reg_index(reg_index),
    .write_data(write_data),
    .failures(failures),
    .bytes_due(bytes_due)
  );

  // Hard stop in case the block hangs.
  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("TEST FAILED");
    $finish;
  end

  // Offer one request and hold it until the block takes it.
  task automatic send_request(logic [7:0] b, logic eos);
    in_item_t req;
    req.in_byte = b;
    req.end_of_stream = eos;
    item <= req;
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sent_items++;
  endtask

  task automatic sender_gap();
    if (!calm && gappy && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    sender_gap();
    send_request(b, 1'b0);
  endtask

  // The byte lane of an end-of-stream request carries noise.
  task automatic send_flush();
    sender_gap();
    send_request(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Mostly printable text with needle bytes mixed in, and now and then any byte.
  function automatic logic [7:0] filler_byte();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    if (needle_used != 0 && $urandom_range(0, 2) == 0)
      return needle_text[$urandom_range(0, needle_used - 1)];
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // Needle bytes that are neither zero nor a newline.
  function automatic logic [63:0] text_word();
    logic [63:0] w;
    for (int k = 0; k < 8; k++) w[8*k +: 8] = 8'($urandom_range(8'h21, 8'hFF));
    return w;
  endfunction

  // One line: filler, optionally the needle, filler, then a newline or a flush.
  task automatic send_line(bit plant, int pre, int post, bit flush);
    gappy = ($urandom_range(0, 2) != 0);
    repeat (pre) send_byte(filler_byte());
    if (plant) begin
      for (int k = 0; k < needle_used; k++) send_byte(needle_text[k]);
    end
    repeat (post) send_byte(filler_byte());
    if (flush) send_flush();
    else send_byte(NEWLINE_BYTE);
  endtask

  // Stop offering requests and wait until every owed byte has come out.
  task automatic settle();
    push <= 1'b0;
    do @(posedge clk); while (bytes_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= data;
    @(posedge clk);
  endtask

  // Reprogram the needle while the block is idle and keep a copy for stimulus.
  task automatic set_needle(logic [63:0] lo, logic [63:0] hi, logic [63:0] len_word);
    int n;
    settle();
    write_reg(REG_NEEDLE_LOW, lo);
    write_reg(REG_NEEDLE_HIGH, hi);
    write_reg(REG_NEEDLE_LENGTH, len_word);
    write_enable <= 1'b0;
    for (int k = 0; k < 8; k++) begin
      needle_text[k] = lo[8*k +: 8];
      needle_text[k+8] = hi[8*k +: 8];
    end
    n = int'(len_word[LEN_W-1:0]);
    needle_used = (n > NEEDLE_MAX) ? NEEDLE_MAX : n;
  endtask

  // Mostly lines that hold the needle, with long lines, noise and flushes.
  task automatic random_phase(int budget);
    int stop;
    stop = sent_items + budget;
    while (sent_items < stop) begin
      case ($urandom_range(0, 19))
        0:       send_line(1'($urandom_range(0, 1)), $urandom_range(40, 80),
                           $urandom_range(0, 20), 1'b0);
        1, 2:    send_line(1'b0, $urandom_range(0, 10), 0, 1'($urandom_range(0, 1)));
        3:       send_flush();
        4, 5:    send_line(1'b1, $urandom_range(0, 6), $urandom_range(0, 6), 1'b1);
        default: send_line(1'b1, $urandom_range(0, 6), $urandom_range(0, 6), 1'b0);
      endcase
    end
  endtask

  // Result side: random stall bursts, steady stretches and one long hold-off.
  initial begin : result_drain
    int stall_left;
    int steady_left;
    bit held;
    stall_left = 0;
    steady_left = 0;
    held = 1'b0;
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && !held) begin
        held = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (calm || steady_left > 0) begin
        pop <= 1'b1;
        if (steady_left > 0) steady_left--;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        case ($urandom_range(0, 7))
          0: begin
            pop <= 1'b0;
            stall_left = $urandom_range(0, 11);
          end
          1: begin
            pop <= 1'b1;
            steady_left = $urandom_range(20, 60);
          end
          default: pop <= 1'b1;
        endcase
      end
    end
  end

  // Request side and verdict.
  initial begin
    rst <= 1'b1;
    push <= 1'b0;
    item <= '0;
    write_enable <= 1'b0;
    reg_index <= '0;
    write_data <= '0;
    calm <= 1'b0;
    long_hold <= 1'b0;
    sent_items = 0;
    needle_used = 0;
    gappy = 1'b0;
    foreach (needle_text[k]) needle_text[k] = 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Needle length is zero after reset: the line is gathered and dropped.
    send_byte(8'hFF);
    send_byte(NEWLINE_BYTE);
    // End of stream on an empty line does nothing.
    send_flush();

    // Needle "ab"; bytes past the length are junk.
    set_needle(64'hA5A5_A5A5_A5A5_6261, {$urandom, $urandom}, 64'd2);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(NEWLINE_BYTE);
    // A zero byte ahead of the needle blocks the match.
    send_byte(ZERO_BYTE);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(NEWLINE_BYTE);
    // A zero byte after a completed match does not undo it.
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(ZERO_BYTE);
    send_byte(NEWLINE_BYTE);
    // A partial line flushed by end of stream.
    send_byte(8'h78);
    send_byte(8'h61);
    send_byte(8'h62);
    send_flush();

    // A zero byte inside the needle can never match.
    set_needle(64'h1234_5678_9ABC_0061, {$urandom, $urandom}, 64'd2);
    send_byte(8'h61);
    send_byte(ZERO_BYTE);
    send_byte(NEWLINE_BYTE);

    // Needle changed in the middle of a line affects only later bytes.
    send_byte(8'h7A);
    send_byte(8'h61);
    set_needle(64'h0000_0000_0000_6261, {$urandom, $urandom}, 64'd2);
    send_byte(8'h62);
    send_byte(NEWLINE_BYTE);

    // Random phases across needle settings, the extremes among them.
    set_needle(text_word(), text_word(), 64'd1);
    random_phase(PHASE_ITEMS);
    set_needle({$urandom, $urandom}, {$urandom, $urandom}, 64'($urandom_range(2, 8)));
    random_phase(PHASE_ITEMS);
    set_needle(text_word(), text_word(), 64'd16);
    random_phase(PHASE_ITEMS);
    // Length field of 31 with all upper bits set behaves as the full needle.
    set_needle(text_word(), text_word(), '1);
    random_phase(PHASE_ITEMS);
    // Zero length with junk in the upper bits: nothing comes out.
    set_needle(text_word(), text_word(), {$urandom, $urandom} & ~64'h1F);
    random_phase(PHASE_ITEMS / 2);

    // Back-pressure: the result side holds off while matching lines pile up.
    set_needle(text_word(), text_word(), 64'd3);
    calm <= 1'b1;
    long_hold <= 1'b1;
    repeat (4) send_line(1'b1, $urandom_range(2, 6), $urandom_range(2, 6), 1'b0);

    // Last stretch without idling on either side.
    set_needle(text_word(), text_word(), 64'($urandom_range(2, 5)));
    random_phase(PHASE_ITEMS);
    settle();

    if (failures == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
